>>> src/uld_pkg.sv
package uld_pkg;

	// Queue depth between the character front end and the byte back end.
	localparam int unsigned GroupQueueDepth = 4;

	// Offset that maps a printable character onto its six-bit value.
	localparam logic [5:0] CharBias = 6'd32;

	// Number of data characters in one group, minus one (index of the last one).
	localparam logic [1:0] GroupLastIdx = 2'd3;

	// One decoded group as handed from the front end to the back end.
	// Byte zero is the high byte of the 24-bit group and leaves first.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;    // bytes to emit, 1 to 3
		logic [2:0]      lmask;  // bit k set when byte k completes the line count
	} grp_t;

endpackage

>>> src/uld_front.sv
module uld_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic [7:0]    char_in,
	input  logic          line_end,
	output logic          grp_push,
	output uld_pkg::grp_t grp
);
	import uld_pkg::*;

	logic        at_start_q;
	logic [5:0]  line_count_q;
	logic [5:0]  bytes_done_q;
	logic [17:0] group_bits_q;
	logic [1:0]  group_index_q;

	logic [5:0]  six;
	logic [23:0] full_word;
	logic [5:0]  rem;
	logic        has_rem;
	logic [1:0]  n_emit;
	logic        grp_done;

	// Map the character onto its six-bit value; only the low six bits matter.
	assign six       = char_in[5:0] - CharBias;
	assign full_word = {group_bits_q, six};
	assign rem       = line_count_q - bytes_done_q;
	assign has_rem   = (bytes_done_q < line_count_q);
	assign grp_done  = acc && !at_start_q && (group_index_q == GroupLastIdx);

	// Number of bytes still owed by this line, capped at one group.
	always_comb begin
		if (!has_rem) begin
			n_emit = 2'd0;
		end else if (rem >= 6'd3) begin
			n_emit = 2'd3;
		end else begin
			n_emit = rem[1:0];
		end
	end

	// Build the group request for the back end.
	always_comb begin
		grp.bytes[0] = full_word[23:16];
		grp.bytes[1] = full_word[15:8];
		grp.bytes[2] = full_word[7:0];
		grp.cnt      = n_emit;
		grp.lmask[0] = has_rem && (rem == 6'd1);
		grp.lmask[1] = has_rem && (rem == 6'd2);
		grp.lmask[2] = has_rem && (rem == 6'd3);
	end

	assign grp_push = grp_done && (n_emit != 2'd0);

	// Line state: count character, group collection, and clearing at line end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q    <= 1'b1;
			line_count_q  <= '0;
			bytes_done_q  <= '0;
			group_bits_q  <= '0;
			group_index_q <= '0;
		end else if (acc) begin
			if (line_end) begin
				at_start_q    <= 1'b1;
				line_count_q  <= '0;
				bytes_done_q  <= '0;
				group_bits_q  <= '0;
				group_index_q <= '0;
			end else if (at_start_q) begin
				at_start_q    <= 1'b0;
				line_count_q  <= six;
				bytes_done_q  <= '0;
				group_bits_q  <= '0;
				group_index_q <= '0;
			end else if (group_index_q != GroupLastIdx) begin
				group_bits_q  <= {group_bits_q[11:0], six};
				group_index_q <= group_index_q + 2'd1;
			end else begin
				bytes_done_q  <= bytes_done_q + {4'd0, n_emit};
				group_bits_q  <= '0;
				group_index_q <= '0;
			end
		end
	end

	// The emitted byte count never passes the declared count.
	a_done_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_done_q <= line_count_q)
		else $error("bytes done exceeds line count");

	// While waiting for a count character the group state is clear.
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		at_start_q |-> (group_index_q == 2'd0 && bytes_done_q == 6'd0))
		else $error("line start with stale group state");

	// A group request is only made on a completed group.
	a_push_on_group: assert property (@(posedge clk) disable iff (!arst_n)
		grp_push |-> (group_index_q == GroupLastIdx && !at_start_q && grp.cnt != 2'd0))
		else $error("group request outside a completed group");

endmodule

>>> src/uld_queue.sv
module uld_queue #(
	parameter int unsigned Depth = uld_pkg::GroupQueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  uld_pkg::grp_t wdata,
	output logic          full,
	input  logic          rd,
	output uld_pkg::grp_t rdata,
	output logic          empty
);
	import uld_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
	localparam logic [CW-1:0] FullCnt = CW'(Depth);

	grp_t          slot_q [Depth];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == FullCnt);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The fill count stays within the depth.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FullCnt)
		else $error("queue count out of range");

	// Pointers agree with the fill count when the queue is empty.
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wptr_q == rptr_q))
		else $error("queue pointers disagree while empty");

	// A write that was dropped would lose a group.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("group written into a full queue");

endmodule

>>> src/uld_back.sv
module uld_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  uld_pkg::grp_t q_data,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    byte_out,
	output logic          run_last,
	output logic          line_last
);
	import uld_pkg::*;

	grp_t       pk_q;
	logic       pk_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       line_last_q;

	logic       slot_free;
	logic       take;
	logic       pk_last;

	assign slot_free = !out_valid_q || pop;
	assign take      = slot_free && pk_valid_q;
	assign pk_last   = (idx_q == (pk_q.cnt - 2'd1));
	assign q_rd      = !q_empty && (!pk_valid_q || (take && pk_last));

	// Current group and the position of the next byte within it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_valid_q <= 1'b0;
			idx_q      <= '0;
		end else if (q_rd) begin
			pk_valid_q <= 1'b1;
			idx_q      <= '0;
		end else if (take) begin
			if (pk_last) begin
				pk_valid_q <= 1'b0;
				idx_q      <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			pk_q <= q_data;
		end
	end

	// Output register: holds one result until it is popped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q      <= pk_q.bytes[idx_q];
			run_last_q  <= pk_last;
			line_last_q <= pk_q.lmask[idx_q];
		end
	end

	assign empty     = !out_valid_q;
	assign byte_out  = byte_q;
	assign run_last  = run_last_q;
	assign line_last = line_last_q;

	// A held group always has a byte left to send.
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		pk_valid_q |-> (idx_q < pk_q.cnt && pk_q.cnt != 2'd0))
		else $error("byte index past group size");

	// A new group is only fetched once the held one is finished.
	a_fetch_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(q_rd && pk_valid_q) |-> (take && pk_last))
		else $error("group fetched over an unfinished one");

	// After a byte that is not the last of its group, the group stays held at a later byte.
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !pk_last) |=> (pk_valid_q && idx_q != 2'd0))
		else $error("group position lost after a byte");

endmodule

>>> src/uudecode_line_stream_top.sv
// Streaming uudecode of body lines. One encoded character is taken per clock
// through push/full; a character flagged with line_end closes its line. The
// first character of a line sets the decoded byte count, every fourth data
// character after it completes a group of up to three bytes, and bytes beyond
// the line's count are dropped, as is a partial group at line end. Decoded
// bytes leave through empty/pop at one byte per clock while bytes are ready
// and popped, high byte of a group first; run_last marks the last byte of a
// group and line_last the byte that completes the line's count. A completed
// group waits in a queue of GroupDepth entries, is then loaded into the back
// end's group register, and leaves byte by byte through its output register.
// The input side stalls only while the group queue is full.
module uudecode_line_stream_top #(
	parameter int unsigned GroupDepth = uld_pkg::GroupQueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       line_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] byte_out,
	output logic       run_last,
	output logic       line_last
);
	import uld_pkg::*;

	logic acc;
	logic grp_push;
	grp_t grp_w;
	logic q_full;
	logic q_empty;
	logic q_rd;
	grp_t q_data;

	// A character request is taken whenever the group queue has room.
	assign full = q_full;
	assign acc  = push && !q_full;

	uld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.char_in  (char_in),
		.line_end (line_end),
		.grp_push (grp_push),
		.grp      (grp_w)
	);

	uld_queue #(
		.Depth (GroupDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (grp_push),
		.wdata  (grp_w),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	uld_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.byte_out  (byte_out),
		.run_last  (run_last),
		.line_last (line_last)
	);

endmodule

>>> test/uudecode_line_stream_top_test.sv
module uudecode_line_stream_top_test;

	// Receiver idling styles.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	// One decoded byte as the block should deliver it.
	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       line_done;
	} dec_byte_t;

	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_GAP      = 6;
	localparam int STALL_PCT    = 40;
	localparam int RUN_LIMIT    = 1200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       line_end = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] byte_out;
	logic       run_last;
	logic       line_last;

	// Decoder state mirrored on the testbench side.
	logic        want_count = 1'b1;
	logic [5:0]  line_total = '0;
	logic [5:0]  line_sent = '0;
	logic [17:0] grp_acc = '0;
	logic [1:0]  grp_fill = '0;

	dec_byte_t pending_bytes[$];
	int        mismatches = 0;
	int        chars_sent = 0;

	// Sender and receiver knobs.
	bit       gaps_on = 1'b0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int       hold_asks = 0;
	int       hold_taken = 0;
	int       hold_left = 0;
	int       rx_phase = 0;

	uudecode_line_stream_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_in(char_in),
		.line_end(line_end),
		.empty(empty),
		.pop(pop),
		.byte_out(byte_out),
		.run_last(run_last),
		.line_last(line_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode one accepted character and queue the bytes it releases.
	task automatic decode_char(input logic [7:0] ch, input logic eol);
		logic [5:0]  six;
		logic [23:0] word;
		dec_byte_t   got[3];
		int          n;
		int          k;
		six = ch[5:0] - uld_pkg::CharBias;
		n = 0;
		if (want_count) begin
			line_total = six;
			line_sent = '0;
			grp_acc = '0;
			grp_fill = '0;
			want_count = 1'b0;
		end else if (grp_fill < 2'd3) begin
			grp_acc = {grp_acc[11:0], six};
			grp_fill = grp_fill + 2'd1;
		end else begin
			word = {grp_acc, six};
			for (k = 0; k < 3; k++) begin
				if (line_sent < line_total) begin
					line_sent = line_sent + 6'd1;
					got[n].data = word[23 - 8 * k -: 8];
					got[n].run_end = 1'b0;
					got[n].line_done = (line_sent == line_total);
					n++;
				end
			end
			for (k = 0; k < n; k++) begin
				got[k].run_end = (k == n - 1);
				pending_bytes.push_back(got[k]);
			end
			grp_acc = '0;
			grp_fill = '0;
		end
		// A line end clears the line after the character is handled.
		if (eol) begin
			want_count = 1'b1;
			line_total = '0;
			line_sent = '0;
			grp_acc = '0;
			grp_fill = '0;
		end
	endtask

	// Offer one character and hold the request until the block takes it.
	task automatic send_char(input logic [7:0] ch, input logic eol);
		int gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				push = 1'b0;
				gap = $urandom_range(1, MAX_GAP);
				repeat (gap) @(negedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		push = 1'b1;
		char_in = ch;
		line_end = eol;
		@(posedge clk);
		while (full) @(posedge clk);
		decode_char(ch, eol);
		chars_sent++;
		@(negedge clk);
	endtask

	// Encode a six-bit value; zero randomly uses either of its two spellings.
	function automatic logic [7:0] uu_char(input logic [5:0] v);
		if (v == 6'd0)
			return $urandom_range(0, 1) ? 8'h60 : 8'h20;
		return {2'b00, v} + {2'b00, uld_pkg::CharBias};
	endfunction

	// Send a line: count character, whole groups, then a tail of loose characters.
	task automatic send_uu_line(input logic [5:0] count, input int groups, input int tail,
			input bit wild);
		int         total;
		int         i;
		logic [7:0] ch;
		total = groups * 4 + tail;
		send_char(uu_char(count), total == 0);
		for (i = 0; i < total; i++) begin
			if (wild && $urandom_range(0, 3) == 0)
				ch = 8'($urandom_range(0, 255));
			else
				ch = uu_char(6'($urandom_range(0, 63)));
			send_char(ch, i == total - 1);
		end
	endtask

	// A lone count character that also ends its line.
	task automatic test_lone_count;
		send_char(8'h27, 1'b1);
	endtask

	// The trailer line "end" completes no group.
	task automatic test_end_line;
		send_char(8'h65, 1'b0);
		send_char(8'h6E, 1'b0);
		send_char(8'h64, 1'b1);
	endtask

	// A full group of maximum values gives three 0xFF bytes.
	task automatic test_full_bytes;
		send_char(8'h23, 1'b0);
		send_char(8'h5F, 1'b0);
		send_char(8'h5F, 1'b0);
		send_char(8'h5F, 1'b0);
		send_char(8'h5F, 1'b1);
	endtask

	// The count runs out inside the first group; the second group is silent.
	task automatic test_count_exhausted;
		int i;
		send_char(8'h21, 1'b0);
		for (i = 0; i < 4; i++)
			send_char(8'h60, 1'b0);
		for (i = 0; i < 4; i++)
			send_char(8'h00, i == 3);
	endtask

	// Off-alphabet characters wrap, and a partial group at line end is dropped.
	task automatic test_partial_group;
		send_char(8'h22, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'h3F, 1'b0);
		send_char(8'hC0, 1'b0);
		send_char(8'h41, 1'b0);
		send_char(8'h42, 1'b1);
	endtask

	// The receiver holds off while a long line keeps coming, so the input stalls.
	task automatic test_receiver_holdoff;
		gaps_on = 1'b0;
		rx_mode = RX_RANDOM;
		hold_asks++;
		send_uu_line(6'd30, 10, 0, 1'b0);
	endtask

	// Random lines, mostly well formed, with broken lines and noise mixed in.
	task automatic test_random_lines(input int budget, input bit gaps, input rx_mode_t mode);
		int         start;
		int         kind;
		int         count;
		int         n;
		int         i;
		logic [7:0] ch;
		gaps_on = gaps;
		rx_mode = mode;
		start = chars_sent;
		while (chars_sent - start < budget) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, 9);
				send_uu_line(6'(count), (count + 2) / 3, 0, $urandom_range(0, 4) == 0);
			end else if (kind == 6) begin
				send_uu_line(6'($urandom_range(0, 12)), $urandom_range(0, 5), 0, 1'b1);
			end else if (kind == 7) begin
				count = $urandom_range(1, 9);
				send_uu_line(6'(count), (count + 2) / 3, $urandom_range(1, 3), 1'b0);
			end else if (kind == 8) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) begin
					ch = 8'($urandom_range(0, 255));
					send_char(ch, i == n - 1);
				end
			end else begin
				n = $urandom_range(2, 12);
				for (i = 0; i < n; i++)
					send_char(uu_char(6'($urandom_range(0, 63))),
						i == n - 1 || $urandom_range(0, 5) == 0);
			end
		end
	endtask

	// Receiver pop pattern, with a long hold-off when one is requested.
	always @(negedge clk) begin
		rx_phase++;
		if (hold_asks != hold_taken) begin
			hold_taken = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop = 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: begin
					pop = 1'b1;
				end
				RX_RANDOM: begin
					pop = ($urandom_range(0, 99) >= STALL_PCT);
				end
				default: begin
					pop = (rx_phase % 7) >= 3;
				end
			endcase
		end
	end

	// Compare every byte taken from the block with the oldest pending byte.
	always @(posedge clk) begin
		dec_byte_t want;
		if (arst_n && pop && !empty) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte %h run_last %b line_last %b", $time,
					byte_out, run_last, line_last);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (want.data !== byte_out) begin
					$display("%0t: byte_out expected %h, actual %h", $time,
						want.data, byte_out);
					mismatches++;
				end
				if (want.run_end !== run_last) begin
					$display("%0t: run_last expected %b, actual %b", $time,
						want.run_end, run_last);
					mismatches++;
				end
				if (want.line_done !== line_last) begin
					$display("%0t: line_last expected %b, actual %b", $time,
						want.line_done, line_last);
					mismatches++;
				end
			end
		end
	end

	// Run limit.
	initial begin
		#RUN_LIMIT;
		$display("uudecode_line_stream_top: mismatch");
		$finish;
	end

	// Reset, the tests in turn, then drain and report.
	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_lone_count;
		test_end_line;
		test_full_bytes;
		test_count_exhausted;
		test_partial_group;
		test_receiver_holdoff;
		test_random_lines(16, 1'b1, RX_RANDOM);
		test_random_lines(16, 1'b1, RX_PATTERN);
		test_random_lines(16, 1'b0, RX_ALWAYS);
		push = 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("uudecode_line_stream_top: match");
		else
			$display("uudecode_line_stream_top: mismatch");
		$finish;
	end

endmodule

>>> files.f
src/uld_pkg.sv
src/uld_front.sv
src/uld_queue.sv
src/uld_back.sv
src/uudecode_line_stream_top.sv
test/uudecode_line_stream_top_test.sv
